// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers; every user has clk and rst_n in scope.

// Condition holds at every edge outside reset.
`define QDEC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("qdec: invariant violated");

// Consequence holds at the same edge as the antecedent.
`define QDEC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qdec: implication violated");

// Consequence holds at the next edge after the antecedent.
`define QDEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qdec: next-cycle check violated");

`endif

// ----- rtl/core/qdec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qdec_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ENTRY_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned POS_W       = 32;

  localparam logic [ENTRY_W-1:0] ENTRY_FULL = ENTRY_W'(TABLE_DEPTH);

  // Edge source codes carried on in_tuser.
  localparam logic [1:0] FUNC_A    = 2'd0;
  localparam logic [1:0] FUNC_B    = 2'd1;
  localparam logic [1:0] FUNC_MARK = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       line_a;
    logic       line_b;
    logic       marker;
  } qdec_event_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    capture_valid;
    logic                    capture_rising;
    logic [INDEX_W-1:0]      capture_index;
    logic                    capture_full;
  } qdec_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/qdec_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qdec_step
  import qdec_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         step_en,
  input  wire qdec_event_t  evt,
  output qdec_result_t      result
);

  logic signed [POS_W-1:0] count_r, count_nxt;
  logic [ENTRY_W-1:0]      rise_r, rise_nxt;
  logic [ENTRY_W-1:0]      fall_r, fall_nxt;
  logic                    cap_en_r;
  logic                    step_up;
  logic                    step_cnt;
  logic [ENTRY_W-1:0]      sel_entries;

  always_comb begin
    count_nxt   = count_r;
    rise_nxt    = rise_r;
    fall_nxt    = fall_r;
    step_up     = 1'b0;
    step_cnt    = 1'b0;
    sel_entries = evt.marker ? rise_r : fall_r;
    result      = '0;

    unique case (evt.func)
      FUNC_A: begin
        step_cnt = 1'b1;
        step_up  = evt.line_a ^ evt.line_b;
      end
      FUNC_B: begin
        step_cnt = 1'b1;
        step_up  = ~(evt.line_a ^ evt.line_b);
      end
      FUNC_MARK: begin
        if (cap_en_r) begin
          result.capture_rising = evt.marker;
          if (sel_entries >= ENTRY_FULL) begin
            result.capture_full = 1'b1;
          end else begin
            result.capture_valid = 1'b1;
            result.capture_index = sel_entries[INDEX_W-1:0];
            if (evt.marker) begin
              rise_nxt = rise_r + ENTRY_W'(1);
            end else begin
              fall_nxt = fall_r + ENTRY_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Add +1 or -1, wrapping modulo 2^32.
    if (step_cnt) begin
      count_nxt = count_r + (step_up ? POS_W'(1) : {POS_W{1'b1}});
    end
    result.position = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      cap_en_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_en_r <= cfg_wr_data;
      end
      if (step_en) begin
        count_r <= count_nxt;
        rise_r  <= rise_nxt;
        fall_r  <= fall_nxt;
      end
    end
  end

  `QDEC_ASSERT_ALWAYS(a_entries_bound, (rise_r <= ENTRY_FULL) && (fall_r <= ENTRY_FULL))
  `QDEC_ASSERT_ALWAYS(a_valid_xor_full, !(result.capture_valid && result.capture_full))
  `QDEC_ASSERT_NEXT(a_marker_holds_count, step_en && (evt.func == FUNC_MARK), $stable(count_r))
  `QDEC_ASSERT_NEXT(a_idle_holds_tables, !step_en && !$isunknown(rise_r), $stable(rise_r) && $stable(fall_r))

endmodule

`default_nettype wire

// ----- rtl/core/quadrature_decoder_with_edge_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Quadrature x4 decoder with marker-edge position capture.
// Input channel in_*: one beat per pin edge event; in_tuser names the line
// that had the edge (A, B or marker), in_tdata carries the sampled levels.
// Output channel out_*: exactly one beat per input beat, in order, carrying
// the position after the event and the capture record (valid, table,
// index, full flag).
// cfg_wr_en/cfg_wr_data write capture_enable; write only while idle.
// Path: an accepted beat enters the input register, then passes the update
// logic into the output register, where out_tvalid rises; a held output
// register keeps it waiting in the input register.
// Throughput: one beat per cycle unless stalled; the single position adder
// and the one entry compare sit between the input and output registers.
// Reset (rst_n low, synchronous) clears the position, both table counts,
// capture_enable and both stage valid flags.
// When the receiver stalls, the output beat holds, the input register keeps
// one more beat, and in_tready drops once both stages are occupied.
module quadrature_decoder_with_edge_capture
  import qdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] line_a, [1] line_b, [2] marker, [7:3] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] position, [32] capture_valid, [33] capture_rising,
  // [41:34] capture_index, [42] capture_full, [47:43] zero
  output logic [47:0]      out_tdata
);

  qdec_event_t  evt_r;
  logic         in_valid_r;
  logic         advance;
  logic         fire;
  qdec_result_t result;
  qdec_result_t res_r;
  logic         out_valid_r;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers; no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      evt_r.func   <= in_tuser;
      evt_r.line_a <= in_tdata[0];
      evt_r.line_b <= in_tdata[1];
      evt_r.marker <= in_tdata[2];
    end
    if (fire) begin
      res_r <= result;
    end
  end

  qdec_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (fire),
    .evt         (evt_r),
    .result      (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.capture_full, res_r.capture_index,
                       res_r.capture_rising, res_r.capture_valid, res_r.position};

endmodule

`default_nettype wire

// ----- verif/qdec_checker.sv -----
`timescale 1ns / 1ps

module qdec_checker
  import qdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] line_a, [1] line_b, [2] marker, [7:3] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] position, [32] capture_valid, [33] capture_rising,
  // [41:34] capture_index, [42] capture_full, [47:43] zero
  input  logic [47:0] out_tdata,
  output int          error_count,
  output int          pending,
  output int          results_seen,
  output int          captures_seen,
  output int          drops_seen
);

  typedef struct {
    logic signed [POS_W-1:0] position;
    logic                    valid;
    logic                    rising;
    logic [INDEX_W-1:0]      index;
    logic                    full;
  } capture_report_t;

  logic signed [POS_W-1:0] position;
  logic [ENTRY_W-1:0]      rise_fill;
  logic [ENTRY_W-1:0]      fall_fill;
  logic                    capture_on;
  capture_report_t         report_q[$];
  int                      n_err;
  int                      n_res;
  int                      n_cap;
  int                      n_drop;

  // Advance the decoder state by one edge event and build its report.
  function automatic capture_report_t decode_event(logic [1:0] func, logic a, logic b,
                                                   logic m);
    capture_report_t    rep;
    logic [ENTRY_W-1:0] fill;
    rep = '{default: '0};
    case (func)
      FUNC_A: position = (a != b) ? position + 32'sd1 : position - 32'sd1;
      FUNC_B: position = (a == b) ? position + 32'sd1 : position - 32'sd1;
      FUNC_MARK: begin
        if (capture_on) begin
          fill = m ? rise_fill : fall_fill;
          rep.rising = m;
          if (fill >= ENTRY_FULL) begin
            rep.full = 1'b1;
          end else begin
            rep.valid = 1'b1;
            rep.index = fill[INDEX_W-1:0];
            fill = fill + 1'b1;
          end
          if (m) rise_fill = fill;
          else fall_fill = fill;
        end
      end
      default: ;
    endcase
    rep.position = position;
    return rep;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("qdec: %s expected %0d got %0d", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    capture_report_t want;
    capture_report_t got;
    if (!rst_n) begin
      position   = '0;
      rise_fill  = '0;
      fall_fill  = '0;
      capture_on = 1'b0;
      report_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        report_q.push_back(decode_event(in_tuser, in_tdata[0], in_tdata[1], in_tdata[2]));
      if (out_tvalid && out_tready) begin
        got.position = out_tdata[31:0];
        got.valid    = out_tdata[32];
        got.rising   = out_tdata[33];
        got.index    = out_tdata[41:34];
        got.full     = out_tdata[42];
        n_res++;
        if (report_q.size() == 0) begin
          $error("qdec: result beat with no event outstanding");
          n_err++;
        end else begin
          want = report_q.pop_front();
          check_field("position", longint'(want.position), longint'(got.position));
          check_field("capture_valid", want.valid, got.valid);
          check_field("capture_rising", want.rising, got.rising);
          check_field("capture_index", want.index, got.index);
          check_field("capture_full", want.full, got.full);
          if (want.valid) n_cap++;
          if (want.full) n_drop++;
        end
      end
      // Writes must land only while idle (the block does not enforce this); then order against events does not matter.
      if (cfg_wr_en) capture_on = cfg_wr_data;
    end
    error_count   <= n_err;
    pending       <= report_q.size();
    results_seen  <= n_res;
    captures_seen <= n_cap;
    drops_seen    <= n_drop;
  end

endmodule

// ----- verif/tb_quadrature_decoder_with_edge_capture.sv -----
`timescale 1ns / 1ps

module tb_quadrature_decoder_with_edge_capture;
  import qdec_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int IDLE_PCT = 38;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  int   error_count;
  int   pending;
  int   results_seen;
  int   captures_seen;
  int   drops_seen;

  bit   tx_idle_on;
  bit   rx_idle_on;
  int   holdoff_req;
  int   holdoff_done;
  int   quiet_cycles;

  // Encoder line levels and direction for the well-formed part of the stream.
  logic lvl_a;
  logic lvl_b;
  bit   fwd;

  quadrature_decoder_with_edge_capture u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  qdec_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .captures_seen (captures_seen),
    .drops_seen    (drops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    holdoff_done = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_done) begin
        holdoff_done = holdoff_req;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      out_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [1:0] func, input logic a, input logic b,
                            input logic m);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {5'b0, 3'($urandom)};
      in_tuser  <= 2'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, m, b, a};
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding beat has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capture(input logic enable);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enable;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly clean quadrature steps; markers, unused codes and glitches mixed in.
  task automatic random_event(input int mark_pct, input int rise_pct);
    int r;
    r = $urandom_range(99);
    if (r < mark_pct) begin
      send_event(FUNC_MARK, lvl_a, lvl_b, $urandom_range(99) < rise_pct);
    end else if (r < mark_pct + 3) begin
      send_event(FUNC_NONE, 1'($urandom), 1'($urandom), 1'($urandom));
    end else if (r < mark_pct + 10) begin
      send_event(2'($urandom_range(1)), 1'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      if ($urandom_range(99) < 3) fwd = !fwd;
      if ((lvl_a == lvl_b) == fwd) begin
        lvl_a = !lvl_a;
        send_event(FUNC_A, lvl_a, lvl_b, 1'($urandom));
      end else begin
        lvl_b = !lvl_b;
        send_event(FUNC_B, lvl_a, lvl_b, 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= FUNC_A;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    holdoff_req  = 0;
    lvl_a        = 1'b0;
    lvl_b        = 1'b0;
    fwd          = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Capture off: every edge kind and level combination, markers ignored.
    write_capture(1'b0);
    for (int i = 0; i < 4; i++) send_event(FUNC_A, i[0], i[1], i[0]);
    for (int i = 0; i < 4; i++) send_event(FUNC_B, i[0], i[1], i[1]);
    send_event(FUNC_MARK, 1'b1, 1'b0, 1'b1);
    send_event(FUNC_MARK, 1'b0, 1'b1, 1'b0);
    send_event(FUNC_NONE, 1'b1, 1'b1, 1'b1);
    wait_idle();

    // Capture on: first entries of both tables, unused code still inert.
    write_capture(1'b1);
    send_event(FUNC_MARK, 1'b0, 1'b0, 1'b1);
    send_event(FUNC_MARK, 1'b1, 1'b1, 1'b1);
    send_event(FUNC_MARK, 1'b0, 1'b1, 1'b0);
    send_event(FUNC_NONE, 1'b1, 1'b1, 1'b1);
    send_event(FUNC_NONE, 1'b0, 1'b0, 1'b0);
    send_event(FUNC_A, 1'b1, 1'b0, 1'b1);
    send_event(FUNC_B, 1'b0, 1'b0, 1'b0);

    // Rising-heavy markers: run the rising table past full.
    for (int i = 0; i < 560; i++) begin
      tx_idle_on = !(i >= 150 && i < 350);
      rx_idle_on = tx_idle_on;
      random_event(65, 80);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_idle();

    write_capture(1'b0);
    for (int i = 0; i < 170; i++) random_event(30, 50);
    wait_idle();

    // Falling-heavy markers with one long receiver hold-off mid-phase.
    write_capture(1'b1);
    for (int i = 0; i < 500; i++) begin
      if (i == 200) holdoff_req++;
      random_event(65, 20);
    end
    wait_idle();

    $display("tb: %0d event beats checked over capture off/on/off/on phases",
             results_seen);
    $display("tb: %0d positions captured, %0d markers dropped on a full table",
             captures_seen, drops_seen);
    if (error_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
